FILE: sv/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk and held off while arst_n is low
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk and held off while arst_n is low
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/abd_pkg.sv
`timescale 1ns / 1ps

package abd_pkg;

	// field widths
	localparam int LEVEL_W = 16;
	localparam int GAIN_W  = 10;
	localparam int WDATA_W = 16;
	localparam int CFG_IDX_W = 1;

	// default history length
	localparam int HISTORY_DEPTH = 8;

	// fixed point: 32768 is one level, 256 is one gain
	localparam int ONE_LEVEL = 32768;
	localparam int GAIN_ONE  = 256;

	// register reset values
	localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST = 16'd9830;
	localparam logic [GAIN_W-1:0]  GAIN_RST      = 10'd384;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 1'b1;

	// quotient bits produced by the divider
	localparam int DIV_STEPS = 15;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// controller to datapath commands
	typedef struct packed {
		logic accept;
		logic update;
		logic mul;
		logic cmp;
		logic div_step;
		logic load_out;
	} abd_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic beat;
	} abd_stat_t;

endpackage

FILE: sv/abd_ram.sv
`timescale 1ns / 1ps

module abd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

FILE: sv/abd_ctrl.sv
`timescale 1ns / 1ps

module abd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  abd_pkg::abd_stat_t  stat,
	output abd_pkg::abd_cmd_t   cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_MUL,
		ST_CMP,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                       state_q;
	logic [abd_pkg::CNT_W-1:0]    cnt_q;
	logic                         out_valid_q;
	logic                         out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd.accept   = (state_q == ST_IDLE) && in_valid;
		cmd.update   = (state_q == ST_UPDATE);
		cmd.mul      = (state_q == ST_MUL);
		cmd.cmp      = (state_q == ST_CMP);
		cmd.div_step = (state_q == ST_DIV);
		cmd.load_out = (state_q == ST_DONE) && out_free;
	end

	// sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					cnt_q   <= '0;
					state_q <= stat.beat ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == abd_pkg::CNT_W'(abd_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: sv/abd_datapath.sv
`timescale 1ns / 1ps

module abd_datapath #(
	parameter int HISTORY_DEPTH = abd_pkg::HISTORY_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [abd_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [abd_pkg::WDATA_W-1:0]       wr_data,
	input  logic [abd_pkg::LEVEL_W-1:0]       volume,
	output logic                              beat,
	output logic [abd_pkg::LEVEL_W-1:0]       intensity,
	input  abd_pkg::abd_cmd_t                 cmd,
	output abd_pkg::abd_stat_t                stat
);

	localparam int LW  = abd_pkg::LEVEL_W;
	localparam int GW  = abd_pkg::GAIN_W;
	localparam int SW  = $clog2(HISTORY_DEPTH);
	localparam int TW  = $clog2(abd_pkg::ONE_LEVEL * HISTORY_DEPTH + 1);
	localparam int K   = abd_pkg::GAIN_ONE * HISTORY_DEPTH;
	localparam int KW  = $clog2(K + 1);
	localparam int DW  = 15 + KW;
	localparam int PW  = (TW + GW > DW) ? (TW + GW) : DW;
	localparam logic [KW-1:0]      K_C     = KW'(K);
	localparam logic [PW-1:0]      ONE_K   = PW'(abd_pkg::ONE_LEVEL * K);
	localparam logic [LW-1:0]      ONE_LVL = LW'(abd_pkg::ONE_LEVEL);
	localparam logic [SW-1:0]      LAST    = SW'(HISTORY_DEPTH - 1);

	logic [LW-1:0]           min_level_q;
	logic [GW-1:0]           gain_q;
	logic [LW-1:0]           lvl_q;
	logic [SW-1:0]           slot_q;
	logic [HISTORY_DEPTH-1:0] hist_vld_q;
	logic [TW-1:0]           total_q;
	logic [PW-1:0]           t_q;
	logic [PW-1:0]           scaled_q;
	logic [DW-1:0]           rem_q;
	logic [DW-1:0]           den_q;
	logic [LW-1:0]           quo_q;
	logic                    beat_q;
	logic [LW-1:0]           rd_data;
	logic [LW-1:0]           old_lvl;
	logic [LW-1:0]           sat_lvl;
	logic [TW+GW-1:0]        t_prod;
	logic [LW+KW-1:0]        scaled_prod;
	logic                    beat_now;
	logic                    lvl_top;
	logic [PW-1:0]           num_full;
	logic [PW-1:0]           den_full;
	logic [DW:0]             rem_shift;
	logic [DW:0]             rem_diff;
	logic                    rem_ge;

	// history store
	abd_ram #(
		.WIDTH (LW),
		.DEPTH (HISTORY_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.update),
		.re    (cmd.accept),
		.addr  (slot_q),
		.wdata (lvl_q),
		.rdata (rd_data)
	);

	// saturate the incoming level, entries never written read as zero
	assign sat_lvl = (volume > ONE_LVL) ? ONE_LVL : volume;
	assign old_lvl = hist_vld_q[slot_q] ? rd_data : '0;

	// threshold and scaled level products
	assign t_prod      = total_q * gain_q;
	assign scaled_prod = lvl_q * K_C;

	// beat test and divider operands
	assign beat_now = (scaled_q > t_q) && (lvl_q > min_level_q);
	assign num_full = scaled_q - t_q;
	assign den_full = ONE_K - t_q;
	assign stat.beat = beat_now;

	// a full-scale level makes numerator equal divisor: top quotient bit, no remainder
	assign lvl_top = (lvl_q == ONE_LVL);

	// one restoring division step
	assign rem_shift = {rem_q, 1'b0};
	assign rem_diff  = rem_shift - {1'b0, den_q};
	assign rem_ge    = (rem_shift >= {1'b0, den_q});

	// configuration and history control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_level_q <= abd_pkg::MIN_LEVEL_RST;
			gain_q      <= abd_pkg::GAIN_RST;
			slot_q      <= '0;
			hist_vld_q  <= '0;
			total_q     <= '0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					abd_pkg::REG_MIN_LEVEL: min_level_q <= wr_data;
					abd_pkg::REG_GAIN:      gain_q      <= wr_data[GW-1:0];
					default:                min_level_q <= min_level_q;
				endcase
			end
			if (cmd.update) begin
				total_q            <= total_q - TW'(old_lvl) + TW'(lvl_q);
				hist_vld_q[slot_q] <= 1'b1;
				slot_q             <= (slot_q == LAST) ? '0 : slot_q + 1'b1;
			end
		end
	end

	// arithmetic payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			lvl_q <= sat_lvl;
		end
		if (cmd.mul) begin
			t_q      <= PW'(t_prod);
			scaled_q <= PW'(scaled_prod);
		end
		if (cmd.cmp) begin
			beat_q <= beat_now;
			rem_q  <= lvl_top ? '0 : num_full[DW-1:0];
			den_q  <= den_full[DW-1:0];
			quo_q  <= {{(LW-1){1'b0}}, lvl_top};
		end
		if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
			quo_q <= {quo_q[LW-2:0], rem_ge};
		end
		if (cmd.load_out) begin
			beat      <= beat_q;
			intensity <= beat_q ? quo_q : '0;
		end
	end

endmodule

FILE: sv/adaptive_beat_detector.sv
`timescale 1ns / 1ps

// Adaptive beat detector: one volume level in, one beat/intensity result out.
// Input channel (in_valid, in_stall, volume): a transfer happens on a clock
// edge with in_valid high and in_stall low. in_stall stays high while an item
// is being worked on, so one item is processed at a time.
// Output channel (out_valid, out_stall, beat, intensity): the result sits in an
// output register until the receiver takes it; the next item is accepted
// while that result still waits.
// Processing: history update, threshold multiply and compare, then, only when
// there is a beat, 15 steps of the bit-serial intensity divider, before
// out_valid rises. A new item is not taken until the current one is finished
// and handed to the output register.
// Configuration: wr_en/wr_index/wr_data write min_level (index 0) or
// threshold_gain (index 1); write only while the block is idle.
// Reset clears the level history, the running sum and the write slot, and
// loads min_level 9830 and threshold_gain 384. If out_stall holds a result,
// the next finished result waits in the datapath until the output is free.
module adaptive_beat_detector #(
	parameter int HISTORY_DEPTH = abd_pkg::HISTORY_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [abd_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [abd_pkg::WDATA_W-1:0]   wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [abd_pkg::LEVEL_W-1:0]   volume,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          beat,
	output logic [abd_pkg::LEVEL_W-1:0]   intensity
);

	abd_pkg::abd_cmd_t  cmd;
	abd_pkg::abd_stat_t stat;

	// sequencer
	abd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// history, threshold and divider
	abd_datapath #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.volume    (volume),
		.beat      (beat),
		.intensity (intensity),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

FILE: sv/abd_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module abd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        beat,
	input logic [15:0] intensity
);

	// no beat means no intensity
	`ASSERT_IMP(a_zero_intensity, out_valid && !beat, intensity == 16'd0, "intensity without beat")

	// level is at most one, so intensity never goes past one
	`ASSERT_IMP(a_intensity_range, out_valid, intensity <= 16'd32768, "intensity above one")

	// an accepted item keeps the input busy on the next cycle
	`ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall, "input not busy")

	// a stalled result holds
	`ASSERT_NEXT(a_result_hold, out_valid && out_stall,
		out_valid && $stable({beat, intensity}), "stalled result changed")

endmodule

bind adaptive_beat_detector abd_checker u_abd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.beat      (beat),
	.intensity (intensity)
);
